// ===== rtl/x86_bcd_adjust_add_and_alu_defines.svh =====
// ----------------------------------------------------------------------------
// x86 BCD adjust / ADD / ADC / AND ALU - assertion macros
// Shared property wrappers, clocked on clk_i and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef X86_BCD_ADJUST_ADD_AND_ALU_DEFINES_SVH
`define X86_BCD_ADJUST_ADD_AND_ALU_DEFINES_SVH

// same-cycle implication
`define X86BCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define X86BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/x86bcd_pkg.sv =====
// ----------------------------------------------------------------------------
// x86bcd_pkg
// Types, constants and width helpers for the x86 BCD adjust / add / and ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package x86bcd_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned MaxWidth = 64;   // operand width cap, 32..64
  localparam int unsigned IdxW     = $clog2(DataW);

  // BCD constants
  localparam logic [3:0] NibMask    = 4'hF;
  localparam logic [3:0] AdjLimit   = 4'd9;
  localparam logic [3:0] AdjStep    = 4'd6;
  localparam logic [7:0] Base       = 8'd10;
  localparam logic [7:0] Recip      = 8'd205;  // 205 / 2^11 ~ 1/10, exact for bytes
  localparam int unsigned RecipShift = 11;

  // flag mask bit positions
  localparam int unsigned FwCf = 0;
  localparam int unsigned FwOf = 1;
  localparam int unsigned FwAf = 2;
  localparam int unsigned FwPf = 3;
  localparam int unsigned FwSf = 4;
  localparam int unsigned FwZf = 5;

  localparam logic [5:0] FwAdjust = 6'b000101;  // CF, AF
  localparam logic [5:0] FwPsz    = 6'b111000;  // PF, SF, ZF
  localparam logic [5:0] FwArith  = 6'b111111;
  localparam logic [5:0] FwLogic  = 6'b111011;  // all but AF
  localparam logic [5:0] FwNone   = 6'b000000;

  typedef enum logic [2:0] {
    FnAaa = 3'd0,
    FnAas = 3'd1,
    FnAad = 3'd2,
    FnAam = 3'd3,
    FnAdd = 3'd4,
    FnAdc = 3'd5,
    FnAnd = 3'd6
  } func_e;

  localparam logic [1:0] SizeByte = 2'd0;

  typedef struct packed {
    logic [2:0]       func;
    logic [DataW-1:0] dest_value;
    logic [DataW-1:0] src_value;
    logic [1:0]       dest_size;
    logic [1:0]       src_size;
    logic             carry_in;
    logic             aux_in;
  } in_word_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             carry_out;
    logic             overflow_out;
    logic             aux_out;
    logic             parity_out;
    logic             sign_out;
    logic             zero_out;
    logic [5:0]       flags_written;
  } out_word_t;

  // word handed from the execute stage to the flag stage
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] result;
    logic             cf;
    logic             of;
    logic             af;
    logic [1:0]       psz_size;
    logic [5:0]       fw;
  } exec_t;

  function automatic logic [IdxW:0] width_of(input logic [1:0] size);
    int unsigned w;
    w = 8 << size;
    if (w > MaxWidth) w = MaxWidth;
    return (IdxW+1)'(w);
  endfunction

  function automatic logic [IdxW-1:0] msb_of(input logic [1:0] size);
    return IdxW'(width_of(size) - 1'b1);
  endfunction

  function automatic logic [DataW-1:0] mask_of(input logic [1:0] size);
    logic [DataW-1:0] m;
    logic [IdxW:0]    w;
    w = width_of(size);
    for (int i = 0; i < DataW; i++) begin
      m[i] = ((IdxW+1)'(i) < w);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/x86bcd_flag_stage.sv =====
// ----------------------------------------------------------------------------
// x86bcd_flag_stage
// Last pipeline stage: PF/SF/ZF from the result, masking of unwritten flags,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module x86bcd_flag_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire x86bcd_pkg::exec_t ex_i,
  output logic                   valid_o,
  output x86bcd_pkg::out_word_t  out_o
);

  logic                  valid_q;
  x86bcd_pkg::out_word_t out_d, out_q;

  logic [x86bcd_pkg::DataW-1:0] psz_mask;
  logic [x86bcd_pkg::IdxW-1:0]  sign_idx;

  always_comb begin
    psz_mask = x86bcd_pkg::mask_of(ex_i.psz_size);
    sign_idx = x86bcd_pkg::msb_of(ex_i.psz_size);

    out_d.result        = ex_i.result;
    out_d.flags_written = ex_i.fw;
    out_d.carry_out     = ex_i.cf & ex_i.fw[x86bcd_pkg::FwCf];
    out_d.overflow_out  = ex_i.of & ex_i.fw[x86bcd_pkg::FwOf];
    out_d.aux_out       = ex_i.af & ex_i.fw[x86bcd_pkg::FwAf];
    out_d.parity_out    = (~^ex_i.result[7:0]) & ex_i.fw[x86bcd_pkg::FwPf];
    out_d.sign_out      = ex_i.result[sign_idx] & ex_i.fw[x86bcd_pkg::FwSf];
    out_d.zero_out      = ((ex_i.result & psz_mask) == '0) & ex_i.fw[x86bcd_pkg::FwZf];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ex_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

// ===== rtl/x86_bcd_adjust_add_and_alu.sv =====
// ----------------------------------------------------------------------------
// x86_bcd_adjust_add_and_alu
// AAA, AAS, AAD, AAM, ADD, ADC and AND with x86 flag rules, three stages.
// ----------------------------------------------------------------------------
//  channel   | ports                    | handshake
//  ----------+--------------------------+----------------------------------
//  command   | start_i, busy_o, in_i    | word taken when start_i && !busy_o
//  result    | valid_o, out_o           | one-cycle strobe, no back-pressure
//
//  One word per cycle; each word passes through three registered stages
//  (decode/sign-extend, execute add/BCD, flags/output register) before
//  its result strobe on valid_o.
//  busy_o is always low: every stage advances each cycle.
//  Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "x86_bcd_adjust_add_and_alu_defines.svh"

module x86_bcd_adjust_add_and_alu (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire x86bcd_pkg::in_word_t  in_i,
  output logic                       valid_o,
  output x86bcd_pkg::out_word_t      out_o
);

  localparam int unsigned DW = x86bcd_pkg::DataW;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // ---------------- stage 1: decode, mask, sign-extend ----------------
  logic                v1_q;
  x86bcd_pkg::func_e   func1_d, func1_q;
  logic [1:0]          size1_q;
  logic [DW-1:0]       d1_d, d1_q, s1_d, s1_q;
  logic                cin1_d, cin1_q, ain1_q;
  logic [15:0]         ax1_q;
  logic [7:0]          aamq1_d, aamq1_q, aad1_d, aad1_q;

  logic [DW-1:0] dmask, smask, s_raw;
  logic [15:0]   recip_prod, aad_prod;

  always_comb begin
    func1_d = x86bcd_pkg::func_e'(in_i.func);
    dmask   = x86bcd_pkg::mask_of(in_i.dest_size);
    smask   = x86bcd_pkg::mask_of(in_i.src_size);
    s_raw   = in_i.src_value & smask;
    if (s_raw[x86bcd_pkg::msb_of(in_i.src_size)]) begin
      s_raw = s_raw | ~smask;
    end
    s1_d = s_raw & dmask;
    d1_d = in_i.dest_value & dmask;
    cin1_d = in_i.carry_in & (func1_d == x86bcd_pkg::FnAdc);

    // AAM quotient by reciprocal; AAD folds AH*10 + AL
    recip_prod = 16'(in_i.dest_value[7:0]) * 16'(x86bcd_pkg::Recip);
    aamq1_d    = 8'(recip_prod >> x86bcd_pkg::RecipShift);
    aad_prod   = 16'(in_i.dest_value[15:8]) * 16'(x86bcd_pkg::Base)
               + 16'(in_i.dest_value[7:0]);
    aad1_d     = aad_prod[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    func1_q <= func1_d;
    size1_q <= in_i.dest_size;
    d1_q    <= d1_d;
    s1_q    <= s1_d;
    cin1_q  <= cin1_d;
    ain1_q  <= in_i.aux_in;
    ax1_q   <= in_i.dest_value[15:0];
    aamq1_q <= aamq1_d;
    aad1_q  <= aad1_d;
  end

  // ---------------- stage 2: execute ----------------
  x86bcd_pkg::exec_t ex_d, ex_q;

  logic [DW:0]                 sum;
  logic [DW-1:0]               dmask1;
  logic [x86bcd_pkg::IdxW-1:0] top;
  logic                        adj;
  logic [7:0]                  al, ah, aam_rem;

  always_comb begin
    al      = ax1_q[7:0];
    ah      = ax1_q[15:8];
    dmask1  = x86bcd_pkg::mask_of(size1_q);
    top     = x86bcd_pkg::msb_of(size1_q);
    sum     = {1'b0, d1_q} + {1'b0, s1_q} + (DW+1)'(cin1_q);
    adj     = (al[3:0] > x86bcd_pkg::AdjLimit) | ain1_q;
    aam_rem = al - 8'(aamq1_q * x86bcd_pkg::Base);

    ex_d.valid    = v1_q;
    ex_d.result   = '0;
    ex_d.cf       = 1'b0;
    ex_d.of       = 1'b0;
    ex_d.af       = 1'b0;
    ex_d.psz_size = size1_q;
    ex_d.fw       = x86bcd_pkg::FwNone;

    case (func1_q)
      x86bcd_pkg::FnAaa: begin
        ex_d.result = DW'(ax1_q);
        if (adj) begin
          ex_d.result = DW'({ah + 8'd1, 4'd0,
                             (al[3:0] + x86bcd_pkg::AdjStep) & x86bcd_pkg::NibMask});
        end
        ex_d.cf = adj;
        ex_d.af = adj;
        ex_d.fw = x86bcd_pkg::FwAdjust;
      end
      x86bcd_pkg::FnAas: begin
        ex_d.result = DW'(ax1_q);
        if (adj) begin
          ex_d.result = DW'({ah - 8'd1, 4'd0,
                             (al[3:0] - x86bcd_pkg::AdjStep) & x86bcd_pkg::NibMask});
        end
        ex_d.cf = adj;
        ex_d.af = adj;
        ex_d.fw = x86bcd_pkg::FwAdjust;
      end
      x86bcd_pkg::FnAad: begin
        ex_d.result   = DW'(aad1_q);
        ex_d.psz_size = x86bcd_pkg::SizeByte;
        ex_d.fw       = x86bcd_pkg::FwPsz;
      end
      x86bcd_pkg::FnAam: begin
        ex_d.result   = DW'({aamq1_q, aam_rem});
        ex_d.psz_size = x86bcd_pkg::SizeByte;
        ex_d.fw       = x86bcd_pkg::FwPsz;
      end
      x86bcd_pkg::FnAdd, x86bcd_pkg::FnAdc: begin
        ex_d.result = sum[DW-1:0] & dmask1;
        // carry out of the operand width sits just above its top bit
        ex_d.cf = sum[x86bcd_pkg::width_of(size1_q)];
        ex_d.of = (d1_q[top] ^ sum[top]) & (s1_q[top] ^ sum[top]);
        ex_d.af = d1_q[4] ^ s1_q[4] ^ sum[4];
        ex_d.fw = x86bcd_pkg::FwArith;
      end
      x86bcd_pkg::FnAnd: begin
        ex_d.result = d1_q & s1_q;
        ex_d.fw     = x86bcd_pkg::FwLogic;
      end
      default: begin
        ex_d.result = '0;
        ex_d.fw     = x86bcd_pkg::FwNone;
      end
    endcase
  end

  // only the valid bit is cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q.valid <= 1'b0;
    end else begin
      ex_q <= ex_d;
    end
  end

  // ---------------- stage 3: flags and output ----------------
  x86bcd_flag_stage u_flag_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ex_i    (ex_q),
    .valid_o (valid_o),
    .out_o   (out_o)
  );

  // ---------------- assertions ----------------
  `X86BCD_ASSERT_IMPL(a_latency_fwd, accept, ##3 valid_o, "accepted word did not complete")
  `X86BCD_ASSERT_IMPL(a_latency_back, valid_o, $past(accept, 3), "result without a command")
  `X86BCD_ASSERT_IMPL(a_unwritten_zero, valid_o,
    ((out_o.carry_out & ~out_o.flags_written[x86bcd_pkg::FwCf]) |
     (out_o.overflow_out & ~out_o.flags_written[x86bcd_pkg::FwOf]) |
     (out_o.aux_out & ~out_o.flags_written[x86bcd_pkg::FwAf]) |
     (out_o.zero_out & ~out_o.flags_written[x86bcd_pkg::FwZf])) == 1'b0,
    "unwritten flag is set")
  `X86BCD_ASSERT_NEXT(a_adjust_pair, ex_q.valid && (ex_q.fw == x86bcd_pkg::FwAdjust),
    out_o.carry_out == out_o.aux_out, "BCD adjust CF and AF disagree")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - x86 BCD adjust / ADD / ADC / AND ALU testbench
// Drives command words through start_i/busy_o and predicts each result word
// in the testbench. Every valid_o strobe is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------

module tb;
  import x86bcd_pkg::*;

  // function code with no operation behind it
  localparam logic [2:0] FnUndef = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  in_word_t  in_i;
  logic      valid_o;
  out_word_t out_o;

  out_word_t alu_results_q[$];
  out_word_t exp_w;
  int unsigned mismatches;
  int unsigned idle_pct;

  x86_bcd_adjust_add_and_alu dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .valid_o (valid_o),
    .out_o   (out_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned size_width(input logic [1:0] sz);
    int unsigned w;
    w = 8 << sz;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic logic [63:0] width_mask(input int unsigned w);
    if (w >= 64) return {64{1'b1}};
    return (64'd1 << w) - 64'd1;
  endfunction

  // {PF, SF, ZF} of a value at width w
  function automatic logic [2:0] psz_flags(input logic [63:0] v, input int unsigned w);
    return {~^v[7:0], v[w-1], ((v & width_mask(w)) == 64'd0)};
  endfunction

  function automatic out_word_t x86_alu_eval(input in_word_t w);
    out_word_t   o;
    int unsigned dw;
    int unsigned sw;
    logic [63:0] dm;
    logic [63:0] sm;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] cin;
    logic [7:0]  al;
    logic [7:0]  ah;
    o  = '0;
    dw = size_width(w.dest_size);
    sw = size_width(w.src_size);
    dm = width_mask(dw);
    sm = width_mask(sw);
    d  = w.dest_value & dm;
    s  = w.src_value & sm;
    if (s[sw-1]) s = s | ~sm;
    s  = s & dm;
    al = w.dest_value[7:0];
    ah = w.dest_value[15:8];
    case (w.func)
      FnAaa, FnAas: begin
        if (al[3:0] > AdjLimit || w.aux_in) begin
          if (w.func == FnAaa) begin
            al = {4'h0, al[3:0] + AdjStep};
            ah = ah + 8'd1;
          end else begin
            al = {4'h0, al[3:0] - AdjStep};
            ah = ah - 8'd1;
          end
          o.carry_out = 1'b1;
          o.aux_out   = 1'b1;
        end
        o.result        = {48'h0, ah, al};
        o.flags_written = FwAdjust;
      end
      FnAad: begin
        al = ah * Base + al;
        o.result = {56'h0, al};
        {o.parity_out, o.sign_out, o.zero_out} = psz_flags({56'h0, al}, 8);
        o.flags_written = FwPsz;
      end
      FnAam: begin
        ah = al / Base;
        al = al % Base;
        o.result = {48'h0, ah, al};
        {o.parity_out, o.sign_out, o.zero_out} = psz_flags({56'h0, al}, 8);
        o.flags_written = FwPsz;
      end
      FnAdd, FnAdc: begin
        cin = (w.func == FnAdc) ? {63'h0, w.carry_in} : 64'd0;
        r   = (d + s + cin) & dm;
        o.result       = r;
        o.carry_out    = 1'(((d & s) | ((d | s) & ~r)) >> (dw - 1));
        o.overflow_out = 1'(((d ^ r) & (s ^ r)) >> (dw - 1));
        o.aux_out      = 1'((d ^ s ^ r) >> 4);
        {o.parity_out, o.sign_out, o.zero_out} = psz_flags(r, dw);
        o.flags_written = FwArith;
      end
      FnAnd: begin
        r = d & s;
        o.result = r;
        {o.parity_out, o.sign_out, o.zero_out} = psz_flags(r, dw);
        o.flags_written = FwLogic;
      end
      default: begin
        o = '0;
        o.flags_written = FwNone;
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a)
      report_mismatch($sformatf("%s expected %h actual %h", name, e, a));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (alu_results_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_w = alu_results_q.pop_front();
        check_field("result",        exp_w.result,        out_o.result);
        check_field("carry_out",     64'(exp_w.carry_out),     64'(out_o.carry_out));
        check_field("overflow_out",  64'(exp_w.overflow_out),  64'(out_o.overflow_out));
        check_field("aux_out",       64'(exp_w.aux_out),       64'(out_o.aux_out));
        check_field("parity_out",    64'(exp_w.parity_out),    64'(out_o.parity_out));
        check_field("sign_out",      64'(exp_w.sign_out),      64'(out_o.sign_out));
        check_field("zero_out",      64'(exp_w.zero_out),      64'(out_o.zero_out));
        check_field("flags_written", 64'(exp_w.flags_written), 64'(out_o.flags_written));
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic send_word(input in_word_t w);
    in_i    <= w;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    alu_results_q.push_back(x86_alu_eval(w));
  endtask

  task automatic idle_cycles(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 13));
  endtask

  function automatic in_word_t mk(input logic [2:0] fn, input logic [63:0] dv,
                                  input logic [63:0] sv, input logic [1:0] ds,
                                  input logic [1:0] ss, input logic c, input logic a);
    in_word_t w;
    w.func       = fn;
    w.dest_value = dv;
    w.src_value  = sv;
    w.dest_size  = ds;
    w.src_size   = ss;
    w.carry_in   = c;
    w.aux_in     = a;
    return w;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int unsigned k;
    v = {$urandom, $urandom};
    k = 8 << $urandom_range(0, 3);
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = {64{1'b1}};
      2: v = width_mask(k) >> 1;            // max positive at width k
      3: v = (width_mask(k) >> 1) + 64'd1;  // sign bit only
      4: v = 64'($urandom_range(0, 31));
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w.func       = (pick < 4) ? FnUndef : 3'($urandom_range(0, 6));
    w.dest_value = rand_operand();
    w.src_value  = rand_operand();
    w.dest_size  = 2'($urandom_range(0, 3));
    w.src_size   = 2'($urandom_range(0, 3));
    w.carry_in   = 1'($urandom);
    w.aux_in     = 1'($urandom);
    // steer BCD adjusts around the 9/10 nibble boundary
    if ((w.func == FnAaa || w.func == FnAas) && $urandom_range(0, 1))
      w.dest_value[3:0] = 4'($urandom_range(8, 11));
    return w;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    idle_pct = 0;
    // adjusts: boundary nibbles, AF forcing, AH wrap, junk above AX
    send_word(mk(FnAaa, 64'h0000_0000_0000_0009, 64'h0, SizeByte, SizeByte, 1'b0, 1'b0));
    send_word(mk(FnAaa, 64'h0000_0000_0000_000A, 64'h0, SizeByte, SizeByte, 1'b0, 1'b0));
    send_word(mk(FnAaa, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 2'd3, 2'd3, 1'b1, 1'b1));
    send_word(mk(FnAaa, 64'h0000_0000_0000_0003, 64'h0, SizeByte, SizeByte, 1'b0, 1'b1));
    send_word(mk(FnAas, 64'h0000_0000_0000_0000, 64'h0, SizeByte, SizeByte, 1'b0, 1'b1));
    send_word(mk(FnAas, 64'h0000_0000_0000_00F9, 64'h0, SizeByte, SizeByte, 1'b1, 1'b0));
    send_word(mk(FnAas, 64'hABCD_0000_0000_FF0F, 64'h0, 2'd1, 2'd2, 1'b0, 1'b0));
    // AAD / AAM
    send_word(mk(FnAad, 64'h0000_0000_0000_FFFF, 64'h0, SizeByte, SizeByte, 1'b0, 1'b0));
    send_word(mk(FnAad, 64'h0000_0000_0000_0000, 64'h0, 2'd3, 2'd3, 1'b1, 1'b1));
    send_word(mk(FnAad, 64'hFFFF_FFFF_FFFF_0C08, 64'h0, 2'd2, 2'd1, 1'b0, 1'b0));
    send_word(mk(FnAam, 64'h0000_0000_0000_00FF, 64'h0, SizeByte, SizeByte, 1'b0, 1'b0));
    send_word(mk(FnAam, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, SizeByte, SizeByte, 1'b1, 1'b1));
    send_word(mk(FnAam, 64'h0000_0000_0000_0063, 64'h0, 2'd1, 2'd1, 1'b0, 1'b0));
    // ADD / ADC extremes at each width
    send_word(mk(FnAdd, 64'hFF, 64'hFF, SizeByte, SizeByte, 1'b1, 1'b0));
    send_word(mk(FnAdd, 64'h7FFF, 64'h0001, 2'd1, 2'd1, 1'b0, 1'b0));
    send_word(mk(FnAdd, 64'h8000_0000, 64'h8000_0000, 2'd2, 2'd2, 1'b0, 1'b0));
    send_word(mk(FnAdd, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 2'd3, 2'd3, 1'b0, 1'b0));
    send_word(mk(FnAdc, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 2'd3, 2'd3, 1'b1, 1'b0));
    send_word(mk(FnAdc, 64'h0F, 64'h00, SizeByte, SizeByte, 1'b1, 1'b0));
    // narrow source sign-extended; wide source truncated
    send_word(mk(FnAdd, 64'h0, 64'h80, 2'd3, SizeByte, 1'b0, 1'b0));
    send_word(mk(FnAdc, 64'h1234, 64'hFFFF_FFFF_FFFF_8001, 2'd1, 2'd3, 1'b1, 1'b1));
    // AND
    send_word(mk(FnAnd, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFF, 2'd3, SizeByte, 1'b1, 1'b1));
    send_word(mk(FnAnd, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 2'd3, 2'd3, 1'b0, 1'b0));
    // undefined function code
    send_word(mk(FnUndef, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 2'd3,
                 1'b1, 1'b1));
    idle_cycles(1);
  endtask

  task automatic test_random_traffic(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      // change the idle rate now and then so no-idle stretches occur too
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      send_word(rand_word());
      maybe_idle();
    end
  endtask

  task automatic test_drain_pause();
    idle_pct = 0;
    repeat (8) send_word(rand_word());
    start_i <= 1'b0;
    while (alu_results_q.size() != 0) @(posedge clk_i);
    repeat (8) send_word(rand_word());
  endtask

  task automatic test_back_to_back(input int unsigned n);
    idle_pct = 0;
    repeat (n) send_word(rand_word());
    start_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    mismatches = 0;
    idle_pct   = 0;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    in_i       = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(600);
    test_drain_pause();
    test_random_traffic(600);
    test_back_to_back(220);

    while (alu_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
